@@ rtl/parity_framed_prefix_code_decoder_assert.svh @@
// assertion macros used by the checker of the decoder
`ifndef PARITY_FRAMED_PREFIX_CODE_DECODER_ASSERT_SVH
`define PARITY_FRAMED_PREFIX_CODE_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PFPCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PFPCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pfpcd_pkg.sv @@
package pfpcd_pkg;

    localparam int unsigned MAX_CODE_LEN    = 10;
    localparam int unsigned TABLE_AW        = MAX_CODE_LEN + 1;
    localparam int unsigned TABLE_DEPTH     = 2 << MAX_CODE_LEN;
    localparam int unsigned CNT_W           = $clog2(MAX_CODE_LEN + 1);
    localparam int unsigned FRAME_DATA_BITS = 8;
    localparam int unsigned FRAME_CNT_W     = $clog2(FRAME_DATA_BITS + 1);
    localparam int unsigned BIT_IDX_W       = $clog2(FRAME_DATA_BITS);
    localparam int unsigned CMDQ_DEPTH      = 2;
    localparam int unsigned CMDQ_AW         = $clog2(CMDQ_DEPTH);
    localparam int unsigned RES_DEPTH       = 16;
    localparam int unsigned RES_AW          = $clog2(RES_DEPTH);
    localparam int unsigned SYM_W           = 8;
    localparam int unsigned COUNT_W         = 16;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_DATA    = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_FRAME   = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [3:0]  code_length;
        logic [9:0]  code_bits;
        logic [7:0]  symbol_in;
        logic [3:0]  nibble;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  symbol;
        logic        code_error;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
    } tbl_word_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [TABLE_AW-1:0]        addr;
        tbl_word_t                  entry;
        logic [FRAME_DATA_BITS-1:0] data;
    } cmd_t;

endpackage

@@ rtl/pfpcd_front.sv @@
module pfpcd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pfpcd_pkg::in_item_t item,
    input  logic              q_full,
    input  logic              sweeping,
    output logic              q_push,
    output pfpcd_pkg::cmd_t   q_cmd
);
    import pfpcd_pkg::*;

    logic [FRAME_DATA_BITS-1:0] frame_data_reg, frame_data_next;
    logic [FRAME_CNT_W-1:0]     frame_count_reg, frame_count_next;
    logic                       frame_parity_reg, frame_parity_next;

    logic [FRAME_DATA_BITS-1:0] fd;
    logic [FRAME_CNT_W-1:0]     fc;
    logic                       fp;
    logic                       frame_done;
    logic [FRAME_DATA_BITS-1:0] frame_byte;
    logic                       accept;
    logic                       len_ok;
    logic [TABLE_AW-1:0]        len_one;

    assign full   = q_full | sweeping;
    assign accept = push & ~full;

    // walk the four nibble bits msb first; at most one frame closes per nibble
    always_comb
    begin
        fd         = frame_data_reg;
        fc         = frame_count_reg;
        fp         = frame_parity_reg;
        frame_done = 1'b0;
        frame_byte = '0;
        for (int b = 3; b >= 0; b--)
        begin
            fp = fp ^ item.nibble[b];
            if (fc >= FRAME_CNT_W'(FRAME_DATA_BITS))
            begin
                if (fp)
                begin
                    frame_done = 1'b1;
                    frame_byte = fd;
                end
                fd = '0;
                fc = '0;
                fp = 1'b0;
            end
            else
            begin
                fd = FRAME_DATA_BITS'({fd, item.nibble[b]});
                fc = fc + FRAME_CNT_W'(1);
            end
        end
    end

    assign len_ok  = (item.code_length != 4'd0) &&
                     (item.code_length <= 4'(MAX_CODE_LEN));
    assign len_one = TABLE_AW'(1) << item.code_length;

    always_comb
    begin
        q_push            = 1'b0;
        q_cmd.kind        = CMD_RESTART;
        q_cmd.addr        = len_one | (TABLE_AW'(item.code_bits) & (len_one - TABLE_AW'(1)));
        q_cmd.entry.valid = item.symbol_in != 8'd0;
        q_cmd.entry.sym   = item.symbol_in;
        q_cmd.data        = frame_byte;
        frame_data_next   = frame_data_reg;
        frame_count_next  = frame_count_reg;
        frame_parity_next = frame_parity_reg;
        unique case (item.opcode)
            OP_CLEAR:
            begin
                q_cmd.kind        = CMD_CLEAR;
                q_push            = accept;
                frame_data_next   = '0;
                frame_count_next  = '0;
                frame_parity_next = 1'b0;
            end
            OP_RESTART:
            begin
                q_cmd.kind        = CMD_RESTART;
                q_push            = accept;
                frame_data_next   = '0;
                frame_count_next  = '0;
                frame_parity_next = 1'b0;
            end
            OP_LOAD:
            begin
                q_cmd.kind = CMD_LOAD;
                q_push     = accept & len_ok;
            end
            OP_DATA:
            begin
                q_cmd.kind        = CMD_FRAME;
                q_push            = accept & frame_done;
                frame_data_next   = fd;
                frame_count_next  = fc;
                frame_parity_next = fp;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_data_reg   <= '0;
            frame_count_reg  <= '0;
            frame_parity_reg <= 1'b0;
        end
        else if (accept)
        begin
            frame_data_reg   <= frame_data_next;
            frame_count_reg  <= frame_count_next;
            frame_parity_reg <= frame_parity_next;
        end
    end

endmodule

@@ rtl/pfpcd_cmd_queue.sv @@
module pfpcd_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  pfpcd_pkg::cmd_t wr_cmd,
    output logic            q_full,
    input  logic            rd_en,
    output pfpcd_pkg::cmd_t rd_cmd,
    output logic            rd_valid
);
    import pfpcd_pkg::*;

    cmd_t                 slots_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg;
    logic [CMDQ_AW-1:0]   rd_ptr_reg;
    logic [CMDQ_AW:0]     count_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign q_full   = count_reg == (CMDQ_AW + 1)'(CMDQ_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_en & ~q_full;
    assign do_rd    = rd_en & rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (CMDQ_AW + 1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (CMDQ_AW + 1)'(1);
            end
        end
    end

endmodule

@@ rtl/pfpcd_back.sv @@
module pfpcd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 cmd_valid,
    input  pfpcd_pkg::cmd_t      cmd,
    output logic                 cmd_pop,
    output logic                 sweeping,
    output pfpcd_pkg::out_item_t result,
    output logic                 empty,
    input  logic                 pop
);
    import pfpcd_pkg::*;

    typedef enum logic [3:0] {
        ST_SWEEP  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_BITS   = 4'b0100,
        ST_FINISH = 4'b1000
    } back_state_t;

    back_state_t                state_reg, state_next;
    logic [TABLE_AW-1:0]        sweep_idx_reg, sweep_idx_next;
    logic [MAX_CODE_LEN-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [COUNT_W-1:0]         emitted_reg, emitted_next;
    logic [COUNT_W-1:0]         max_symbols_reg;
    logic [FRAME_DATA_BITS-1:0] byte_reg, byte_next;
    logic [BIT_IDX_W-1:0]       bit_idx_reg, bit_idx_next;
    logic                       pend_valid_reg, pend_valid_next;
    out_item_t                  pend_reg, pend_next;

    tbl_word_t                  table_mem [TABLE_DEPTH];
    tbl_word_t                  rdata_reg;
    logic                       mem_we;
    logic [TABLE_AW-1:0]        mem_waddr;
    tbl_word_t                  mem_wdata;
    logic [TABLE_AW-1:0]        mem_raddr;

    out_item_t                  res_mem [RES_DEPTH];
    logic [RES_AW-1:0]          res_wr_ptr_reg;
    logic [RES_AW-1:0]          res_rd_ptr_reg;
    logic [RES_AW:0]            res_fill_reg;
    logic                       res_push;
    out_item_t                  res_push_item;
    logic                       res_pop;

    logic                       hit;
    logic                       overrun;
    logic [MAX_CODE_LEN-1:0]    acc_eff;
    logic [CNT_W-1:0]           cnt_eff;
    logic                       shift_bit;
    logic [MAX_CODE_LEN-1:0]    acc_sh;
    logic [CNT_W-1:0]           cnt_sh;
    logic                       new_valid;
    out_item_t                  new_res;

    assign sweeping = state_reg == ST_SWEEP;

    // operands of the next shift: in BITS the previous lookup settles first
    assign hit     = rdata_reg.valid;
    assign overrun = cnt_reg >= CNT_W'(MAX_CODE_LEN);

    always_comb
    begin
        if (state_reg == ST_BITS)
        begin
            acc_eff   = (hit || overrun) ? '0 : acc_reg;
            cnt_eff   = (hit || overrun) ? '0 : cnt_reg;
            shift_bit = byte_reg[FRAME_DATA_BITS-2];
        end
        else
        begin
            acc_eff   = acc_reg;
            cnt_eff   = cnt_reg;
            shift_bit = cmd.data[FRAME_DATA_BITS-1];
        end
    end

    assign acc_sh    = MAX_CODE_LEN'({acc_eff, shift_bit});
    assign cnt_sh    = cnt_eff + CNT_W'(1);
    assign mem_raddr = (TABLE_AW'(1) << cnt_sh) | TABLE_AW'(acc_sh);

    always_comb
    begin
        new_valid = 1'b0;
        new_res   = '0;
        if (state_reg == ST_BITS)
        begin
            if (hit)
            begin
                new_valid      = emitted_reg < max_symbols_reg;
                new_res.symbol = rdata_reg.sym;
            end
            else if (overrun)
            begin
                new_valid          = 1'b1;
                new_res.code_error = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_idx_next  = sweep_idx_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        emitted_next    = emitted_reg;
        byte_next       = byte_reg;
        bit_idx_next    = bit_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_idx_reg;
        mem_wdata       = '0;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_push_item   = pend_reg;

        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we         = 1'b1;
                sweep_idx_next = sweep_idx_reg + TABLE_AW'(1);
                if (sweep_idx_reg == TABLE_AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_CLEAR:
                        begin
                            cmd_pop        = 1'b1;
                            acc_next       = '0;
                            cnt_next       = '0;
                            emitted_next   = '0;
                            sweep_idx_next = '0;
                            state_next     = ST_SWEEP;
                        end
                        CMD_RESTART:
                        begin
                            cmd_pop      = 1'b1;
                            acc_next     = '0;
                            cnt_next     = '0;
                            emitted_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            cmd_pop   = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = cmd.addr;
                            mem_wdata = cmd.entry;
                        end
                        CMD_FRAME:
                        begin
                            // room for every result one frame can give
                            if (res_fill_reg <= (RES_AW + 1)'(RES_DEPTH - FRAME_DATA_BITS))
                            begin
                                cmd_pop      = 1'b1;
                                byte_next    = cmd.data;
                                acc_next     = acc_sh;
                                cnt_next     = cnt_sh;
                                bit_idx_next = '0;
                                state_next   = ST_BITS;
                            end
                        end
                    endcase
                end
            end
            ST_BITS:
            begin
                if (hit && (emitted_reg < max_symbols_reg) && (emitted_reg != '1))
                begin
                    emitted_next = emitted_reg + COUNT_W'(1);
                end
                // hold back the newest result until it is known whether it is the last
                if (new_valid)
                begin
                    res_push        = pend_valid_reg;
                    pend_next       = new_res;
                    pend_valid_next = 1'b1;
                end
                if (bit_idx_reg == BIT_IDX_W'(FRAME_DATA_BITS - 1))
                begin
                    acc_next   = acc_eff;
                    cnt_next   = cnt_eff;
                    state_next = pend_valid_next ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    acc_next     = acc_sh;
                    cnt_next     = cnt_sh;
                    byte_next    = FRAME_DATA_BITS'({byte_reg, 1'b0});
                    bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                res_push           = 1'b1;
                res_push_item.last = 1'b1;
                pend_valid_next    = 1'b0;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= table_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        pend_reg <= pend_next;
        if (res_push)
        begin
            res_mem[res_wr_ptr_reg] <= res_push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            sweep_idx_reg   <= '0;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            emitted_reg     <= '0;
            bit_idx_reg     <= '0;
            pend_valid_reg  <= 1'b0;
            max_symbols_reg <= '1;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_idx_reg  <= sweep_idx_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            emitted_reg    <= emitted_next;
            bit_idx_reg    <= bit_idx_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_wr_en)
            begin
                max_symbols_reg <= cfg_wr_data;
            end
        end
    end

    // result queue
    assign empty   = res_fill_reg == '0;
    assign result  = res_mem[res_rd_ptr_reg];
    assign res_pop = pop & ~empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_fill_reg   <= '0;
        end
        else
        begin
            if (res_push)
            begin
                res_wr_ptr_reg <= res_wr_ptr_reg + RES_AW'(1);
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= res_rd_ptr_reg + RES_AW'(1);
            end
            if (res_push && !res_pop)
            begin
                res_fill_reg <= res_fill_reg + (RES_AW + 1)'(1);
            end
            else if (res_pop && !res_push)
            begin
                res_fill_reg <= res_fill_reg - (RES_AW + 1)'(1);
            end
        end
    end

endmodule

@@ rtl/parity_framed_prefix_code_decoder.sv @@
// result path: a nibble closing a passing frame queues a command; BITS walks its data bits
// with a registered table lookup, and each result waits for the next one or for FINISH
// flow: items enter a 2-deep command queue whenever full is low; the decode side pops load
// and restart from idle, walks a passing frame in BITS, then FINISH if it gave any result
// clear and reset: a sweep empties the code table with full high; reset also
// clears the stream state and queues and sets max_symbols to 65535
module parity_framed_prefix_code_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pfpcd_pkg::in_item_t  item,
    output logic                 empty,
    input  logic                 pop,
    output pfpcd_pkg::out_item_t result,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data
);
    import pfpcd_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic sweeping;

    pfpcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .q_full   (q_full),
        .sweeping (sweeping),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    pfpcd_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_cmd   (q_cmd),
        .q_full   (q_full),
        .rd_en    (cmd_pop),
        .rd_cmd   (cmd),
        .rd_valid (cmd_valid)
    );

    pfpcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .sweeping    (sweeping),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

@@ rtl/pfpcd_checker.sv @@
`include "parity_framed_prefix_code_decoder_assert.svh"

module pfpcd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 empty,
    input logic                 pop,
    input pfpcd_pkg::out_item_t result
);
    import pfpcd_pkg::*;

    `PFPCD_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(result), "result changed while waiting")
    `PFPCD_ASSERT_SAME(a_err_zero_sym, !empty && result.code_error, result.symbol == 8'd0, "error result carries a symbol")
    `PFPCD_ASSERT_SAME(a_sym_nonzero, !empty && !result.code_error, result.symbol != 8'd0, "empty table entry decoded")

endmodule

bind parity_framed_prefix_code_decoder pfpcd_checker u_pfpcd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import pfpcd_pkg::*;

    localparam int IN_W        = $bits(in_item_t);
    localparam int STUCK_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   result;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;

    // decoder state as the testbench sees it
    logic [7:0]              code_sym [TABLE_DEPTH];
    bit                      code_ok [TABLE_DEPTH];
    logic [MAX_CODE_LEN-1:0] acc = '0;
    int unsigned             acc_len = 0;
    logic [7:0]              frm_data = '0;
    int unsigned             frm_len = 0;
    bit                      frm_par = 1'b0;
    logic [15:0]             emitted = '0;
    logic [15:0]             sym_limit = 16'hFFFF;

    out_item_t   symbols_due[$];
    bit          sweep_sent = 1'b0;
    int          errs = 0;
    int unsigned items_sent = 0;
    int unsigned stuck = 0;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    bit          hold_off = 1'b0;
    int unsigned hold_left = 0;

    // current prefix code and the wire bits waiting to go out as nibbles
    int unsigned leaf_len[$];
    logic [9:0]  leaf_code[$];
    bit          line_bits[$];

    parity_framed_prefix_code_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    function automatic void restart_stream();
        acc = '0;
        acc_len = 0;
        frm_data = '0;
        frm_len = 0;
        frm_par = 1'b0;
        emitted = '0;
    endfunction

    function automatic void decode_item(input in_item_t it);
        out_item_t   got[$];
        out_item_t   r;
        int unsigned idx;
        case (it.opcode)
            OP_CLEAR:
            begin
                foreach (code_ok[i]) code_ok[i] = 1'b0;
                restart_stream();
                sweep_sent = 1'b1;
            end
            OP_RESTART:
            begin
                restart_stream();
            end
            OP_LOAD:
            begin
                if (it.code_length != 0 && it.code_length <= MAX_CODE_LEN)
                begin
                    idx = (1 << it.code_length) | (it.code_bits & ((1 << it.code_length) - 1));
                    code_sym[idx] = it.symbol_in;
                    code_ok[idx] = (it.symbol_in != 0);
                end
            end
            default:
            begin
                for (int k = 3; k >= 0; k--)
                begin
                    frm_par ^= it.nibble[k];
                    if (frm_len >= 8)
                    begin
                        // ninth bit closes the frame; odd ones pass
                        if (frm_par)
                        begin
                            for (int j = 7; j >= 0; j--)
                            begin
                                acc = {acc[MAX_CODE_LEN-2:0], frm_data[j]};
                                acc_len++;
                                idx = (1 << acc_len) | acc;
                                if (code_ok[idx])
                                begin
                                    acc = '0;
                                    acc_len = 0;
                                    if (emitted < sym_limit)
                                    begin
                                        if (emitted != 16'hFFFF) emitted++;
                                        r.symbol = code_sym[idx];
                                        r.code_error = 1'b0;
                                        r.last = 1'b0;
                                        got = {got, r};
                                    end
                                end
                                else if (acc_len >= MAX_CODE_LEN)
                                begin
                                    acc = '0;
                                    acc_len = 0;
                                    r.symbol = 8'd0;
                                    r.code_error = 1'b1;
                                    r.last = 1'b0;
                                    got = {got, r};
                                end
                            end
                        end
                        frm_data = '0;
                        frm_len = 0;
                        frm_par = 1'b0;
                    end
                    else
                    begin
                        frm_data = {frm_data[6:0], it.nibble[k]};
                        frm_len++;
                    end
                end
                if (got.size() != 0) got[got.size() - 1].last = 1'b1;
                foreach (got[i]) symbols_due = {symbols_due, got[i]};
            end
        endcase
    endfunction

    // result checking and input tracking share one process so their order is fixed
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (symbols_due.size() == 0)
            begin
                $error("result with nothing pending: symbol %0d code_error %0b last %0b",
                       result.symbol, result.code_error, result.last);
                errs++;
            end
            else
            begin
                want = symbols_due.pop_front();
                if (result.symbol !== want.symbol)
                begin
                    $error("symbol: expected %0d, got %0d", want.symbol, result.symbol);
                    errs++;
                end
                if (result.code_error !== want.code_error)
                begin
                    $error("code_error: expected %0b, got %0b", want.code_error,
                           result.code_error);
                    errs++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, result.last);
                    errs++;
                end
            end
        end
        if (rst_n && push && !full) decode_item(item);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stuck <= 0;
        end
        else if (stuck >= STUCK_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
        begin
            stuck <= stuck + 1;
        end
    end

    // receiver: random pop, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_off)
        begin
            pop <= 1'b0;
            hold_off <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic in_item_t rand_item(input opcode_t op);
        in_item_t it;
        it = in_item_t'(IN_W'($urandom));
        it.opcode = op;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_load(input logic [3:0] len, input logic [9:0] code,
                             input logic [7:0] sym);
        in_item_t it;
        it = rand_item(OP_LOAD);
        it.code_length = len;
        it.code_bits = code;
        it.symbol_in = sym;
        send_item(it);
    endtask

    function automatic void add_frame(input logic [7:0] data, input bit good);
        for (int i = 7; i >= 0; i--) line_bits = {line_bits, bit'(data[i])};
        line_bits = {line_bits, bit'(good ? ~^data : ^data)};
    endfunction

    task automatic flush_line();
        in_item_t it;
        while (line_bits.size() % 4 != 0) line_bits = {line_bits, bit'($urandom)};
        while (line_bits.size() != 0)
        begin
            it = rand_item(OP_DATA);
            for (int i = 3; i >= 0; i--) it.nibble[i] = line_bits.pop_front();
            send_item(it);
        end
    endtask

    // random prefix code from splitting leaves of a binary tree
    task automatic load_random_code(input int unsigned n_leaves, input bit complete);
        int unsigned k;
        leaf_len = {1, 1};
        leaf_code = {10'd0, 10'd1};
        while (leaf_len.size() < n_leaves)
        begin
            k = $urandom_range(leaf_len.size() - 1);
            if (leaf_len[k] < MAX_CODE_LEN)
            begin
                leaf_len = {leaf_len, leaf_len[k] + 1};
                leaf_code = {leaf_code, {leaf_code[k][8:0], 1'b1}};
                leaf_len[k]++;
                leaf_code[k] = {leaf_code[k][8:0], 1'b0};
            end
        end
        // a missing leaf leaves bit paths that end in a code error
        if (!complete)
        begin
            k = $urandom_range(leaf_len.size() - 1);
            leaf_len.delete(k);
            leaf_code.delete(k);
        end
        foreach (leaf_len[i])
            send_load(4'(leaf_len[i]), (10'($urandom) << leaf_len[i]) | leaf_code[i],
                      8'($urandom_range(1, 255)));
    endtask

    task automatic send_symbols(input int unsigned n_syms, input int unsigned junk_pct,
                                input int unsigned bad_pct);
        bit          bits[$];
        logic [7:0]  data;
        int unsigned k;
        repeat (n_syms)
        begin
            k = $urandom_range(leaf_len.size() - 1);
            for (int i = leaf_len[k] - 1; i >= 0; i--) bits = {bits, bit'(leaf_code[k][i])};
            if ($urandom_range(99) < junk_pct)
                repeat ($urandom_range(1, 3)) bits = {bits, bit'($urandom)};
        end
        while (bits.size() != 0)
        begin
            for (int i = 7; i >= 0; i--)
                data[i] = (bits.size() != 0) ? bits.pop_front() : 1'($urandom);
            add_frame(data, $urandom_range(99) >= bad_pct);
        end
        flush_line();
    endtask

    task automatic send_noise(input int unsigned n);
        int unsigned pick;
        repeat (n)
        begin
            pick = $urandom_range(2);
            send_item(rand_item(pick == 0 ? OP_LOAD : pick == 1 ? OP_DATA : OP_RESTART));
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (symbols_due.size() != 0) @(posedge clk);
        // a clear sweeps the whole table before the block goes idle
        repeat (sweep_sent ? TABLE_DEPTH + 64 : 64) @(posedge clk);
        sweep_sent = 1'b0;
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sym_limit = value;
    endtask

    task automatic test_directed();
        in_item_t it;
        send_idle = 12;
        recv_idle = 50;
        it = rand_item(OP_CLEAR);
        it.code_length = 4'hF;
        it.code_bits = 10'h3FF;
        it.symbol_in = 8'hFF;
        it.nibble = 4'hF;
        send_item(it);
        send_load(4'd1, 10'h3FE, 8'hFF);   // wide code, masks down to 0
        send_load(4'd10, 10'h3FF, 8'h01);
        send_load(4'd0, 10'h000, 8'h55);   // bad lengths are dropped
        send_load(4'd11, 10'h001, 8'h66);
        send_load(4'd15, 10'h3FF, 8'h77);
        send_load(4'd2, 10'h002, 8'h22);
        send_load(4'd2, 10'h002, 8'h00);   // symbol zero empties the entry
        add_frame(8'h00, 1'b1);            // eight short codes
        add_frame(8'hFF, 1'b1);
        add_frame(8'hC0, 1'b1);            // completes the ten-bit code
        add_frame(8'h12, 1'b0);            // even ones, dropped
        add_frame(8'h80, 1'b1);
        add_frame(8'h00, 1'b1);            // overrun on "1000000000"
        flush_line();
        send_item(rand_item(OP_RESTART));
    endtask

    task automatic test_symbol_limit();
        logic [15:0] caps [4];
        caps = '{16'd0, 16'd1, 16'd5, 16'hFFFF};
        foreach (caps[i])
        begin
            drain();
            write_limit(caps[i]);
            if (i == 0) load_random_code(4, 1'b1);
            send_item(rand_item(OP_RESTART));
            send_symbols(10, 0, 0);
            // no restart here, so the count carries on
            send_symbols(6, 0, 0);
        end
    endtask

    task automatic test_backpressure();
        drain();
        send_idle = 0;
        load_random_code(2, 1'b1);
        hold_off <= 1'b1;
        send_item(rand_item(OP_RESTART));
        send_symbols(160, 0, 0);
        send_idle = 12;
    endtask

    task automatic test_random(input int unsigned n_items, input int unsigned s_idle,
                               input int unsigned r_idle);
        int unsigned stop_at;
        drain();
        send_idle = s_idle;
        recv_idle = r_idle;
        write_limit($urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(4, 60)));
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(3) == 0) send_item(rand_item(OP_CLEAR));
            load_random_code($urandom_range(2, 10), $urandom_range(9) < 7);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(4) != 0) send_item(rand_item(OP_RESTART));
                send_symbols($urandom_range(3, 12), 10, 8);
            end
            if ($urandom_range(99) < 20) send_noise($urandom_range(2, 8));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_symbol_limit();
        test_backpressure();
        test_random(20, 12, 50);
        test_random(20, 50, 12);
        test_random(20, 0, 0);
        drain();
        if (errs == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
